/* hdl/dpoc_pkg.sv */
// Shared types, constants and the pairwise overlap test for the die placement checker.
package dpoc_pkg;

   localparam int COORD_W = 24;
   localparam int SIZE_W  = 23;
   localparam int REQ_W   = 96;
   localparam int RSP_W   = 16;
   localparam int COUNT_W = 7;

   typedef struct packed {
      logic [SIZE_W-1:0]         h;
      logic [SIZE_W-1:0]         w;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } rect_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EMIT
   } state_type;

   // Strict test on one axis: 2*|ca - cb| < sa + sb.
   function automatic logic axis_overlap(input logic signed [COORD_W-1:0] ca,
                                         input logic signed [COORD_W-1:0] cb,
                                         input logic [SIZE_W-1:0] sa,
                                         input logic [SIZE_W-1:0] sb);
      logic signed [COORD_W:0] diff;
      logic [COORD_W:0]        mag;
      logic [COORD_W+1:0]      twice;
      logic [SIZE_W:0]         span;
      diff  = {ca[COORD_W-1], ca} - {cb[COORD_W-1], cb};
      mag   = diff[COORD_W] ? (~diff + 1'b1) : diff;
      twice = {mag, 1'b0};
      span  = {1'b0, sa} + {1'b0, sb};
      return twice < {2'b00, span};
   endfunction

   function automatic logic rect_overlap(input rect_type a, input rect_type b);
      return axis_overlap(a.x, b.x, a.w, b.w) && axis_overlap(a.y, b.y, a.h, b.h);
   endfunction

endpackage

/* hdl/die_placement_overlap_check.sv */
// Flow: a rectangle is taken only in the idle state, and the next word is not taken until
// its walk through the chain of slots, one slot per cycle, is done; the result of a set is
// registered on the output register after its last word. A rectangle dropped past capacity
// is not walked through the chain; if it is marked last, the result of its set is emitted.
// Reset: synchronous, clears the count, flags and handshake state; slots need no clearing.
module die_placement_overlap_check import dpoc_pkg::*; #(
   parameter int MAX_DIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // [23:0] center_x, [47:24] center_y, [70:48] rect_width, [93:71] rect_height, rest zero
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [0] placement_valid, [7:1] rect_count, [8] capacity_overflow, rest zero
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int CNT_W = $clog2(MAX_DIES + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overlap_ff, overlap_in;
   logic             overflow_ff, overflow_in;
   logic             last_ff, last_in;
   logic             launch_ff, launch_in;
   logic [CNT_W-1:0] launch_rem_ff;
   rect_type         launch_rect_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             full;
   logic             done_any;
   logic             hit_any;
   rect_type         req_rect;

   logic             chain_vld  [MAX_DIES+1];
   logic             chain_hit  [MAX_DIES+1];
   logic [CNT_W-1:0] chain_rem  [MAX_DIES+1];
   rect_type         chain_rect [MAX_DIES+1];
   logic             cell_done     [MAX_DIES];
   logic             cell_done_hit [MAX_DIES];

   assign req_rect.x = req_tdata[23:0];
   assign req_rect.y = req_tdata[47:24];
   assign req_rect.w = req_tdata[70:48];
   assign req_rect.h = req_tdata[93:71];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(MAX_DIES));

   assign chain_vld[0]  = launch_ff;
   assign chain_hit[0]  = 1'b0;
   assign chain_rem[0]  = launch_rem_ff;
   assign chain_rect[0] = launch_rect_ff;

   for (genvar i = 0; i < MAX_DIES; i++) begin : g_cell
      dpoc_cell #(
         .CNT_W(CNT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_vld   (chain_vld[i]),
         .up_hit   (chain_hit[i]),
         .up_rem   (chain_rem[i]),
         .up_rect  (chain_rect[i]),
         .dn_vld   (chain_vld[i+1]),
         .dn_hit   (chain_hit[i+1]),
         .dn_rem   (chain_rem[i+1]),
         .dn_rect  (chain_rect[i+1]),
         .done     (cell_done[i]),
         .done_hit (cell_done_hit[i])
      );
   end

   // Only the slot that stored the rectangle reports in a given cycle.
   always_comb begin
      done_any = 1'b0;
      hit_any  = 1'b0;
      for (int i = 0; i < MAX_DIES; i++) begin
         done_any = done_any | cell_done[i];
         hit_any  = hit_any | (cell_done[i] & cell_done_hit[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overlap_ff   <= 1'b0;
         overflow_ff  <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overlap_ff   <= overlap_in;
         overflow_ff  <= overflow_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         launch_rect_ff <= req_rect;
         launch_rem_ff  <= count_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overlap_in   = overlap_ff;
      overflow_in  = overflow_ff;
      last_in      = last_ff;
      launch_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_tlast;
               if (full) begin
                  // drop the rectangle, remember it
                  overflow_in = 1'b1;
                  if (req_tlast) begin
                     state_in = ST_EMIT;
                  end
               end else begin
                  launch_in = 1'b1;
                  state_in  = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (done_any) begin
               count_in   = count_ff + 1'b1;
               overlap_in = overlap_ff | hit_any;
               state_in   = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, overflow_ff, COUNT_W'(count_ff), !overlap_ff};
               count_in     = '0;
               overlap_in   = 1'b0;
               overflow_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hdl/dpoc_cell.sv */
// One slot of the rectangle chain: compares a passing rectangle, or stores it at the free slot.
module dpoc_cell import dpoc_pkg::*; #(
   parameter int CNT_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             up_vld,
   input  logic             up_hit,
   input  logic [CNT_W-1:0] up_rem,
   input  rect_type         up_rect,
   output logic             dn_vld,
   output logic             dn_hit,
   output logic [CNT_W-1:0] dn_rem,
   output rect_type         dn_rect,
   output logic             done,
   output logic             done_hit
);

   rect_type         rect_ff;
   logic             dn_vld_ff;
   logic             dn_hit_ff;
   logic [CNT_W-1:0] dn_rem_ff;
   rect_type         dn_rect_ff;
   logic             done_ff;
   logic             done_hit_ff;
   logic             store;
   logic             hit_now;

   assign store   = up_vld && (up_rem == '0);
   assign hit_now = rect_overlap(up_rect, rect_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         dn_vld_ff <= up_vld && (up_rem != '0);
         done_ff   <= store;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         rect_ff <= up_rect;
      end
      dn_rect_ff  <= up_rect;
      dn_rem_ff   <= up_rem - 1'b1;
      dn_hit_ff   <= up_hit | hit_now;
      done_hit_ff <= up_hit;
   end

   assign dn_vld   = dn_vld_ff;
   assign dn_hit   = dn_hit_ff;
   assign dn_rem   = dn_rem_ff;
   assign dn_rect  = dn_rect_ff;
   assign done     = done_ff;
   assign done_hit = done_hit_ff;

endmodule

/* hdl/dpoc_checker.sv */
// Port-level checks for the die placement checker, bound to the top level.
module dpoc_checker import dpoc_pkg::*; #(
   parameter int MAX_DIES = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             req_tlast,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("word taken right after the last word of a set");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (MAX_DIES > 127) || (rsp_tdata[7:1] <= MAX_DIES))
      else $error("rectangle count above capacity");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[7:1] == COUNT_W'(MAX_DIES))
      else $error("overflow reported without a full store");

   a_small_set_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (MAX_DIES < 128) && (rsp_tdata[7:1] <= 7'd1) |-> rsp_tdata[0])
      else $error("overlap reported in a set of at most one rectangle");

endmodule

bind die_placement_overlap_check dpoc_checker #(
   .MAX_DIES(MAX_DIES)
) u_dpoc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* dv/tb_die_placement_overlap_check.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the die placement overlap checker: directed and random rectangle sets.
module tb_die_placement_overlap_check;
   import dpoc_pkg::*;

   localparam int DIES        = 64;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 2 * DIES + 16;
   localparam int PHASE_ITEMS = 220;

   typedef struct {
      rect_type r;
      bit       last;
   } die_word_type;

   typedef struct {
      bit               placement_valid;
      bit [COUNT_W-1:0] rect_count;
      bit               capacity_overflow;
   } verdict_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tlast  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   die_word_type die_q[$];
   verdict_type  verdict_q[$];
   die_word_type on_bus;

   // Shadow of the placement store and per-set flags
   rect_type    placed[DIES];
   int unsigned placed_count = 0;
   bit          clash_seen   = 1'b0;
   bit          spill_seen   = 1'b0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_req       = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int fail_count     = 0;
   int quiet_cycles   = 0;

   die_placement_overlap_check #(.MAX_DIES(DIES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, int got, int want);
      fail_count++;
      if (fail_count <= 40)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Strict overlap on both axes, computed in wide signed integers
   function automatic bit rects_clash(rect_type a, rect_type b);
      longint dx;
      longint dy;
      dx = longint'($signed(a.x)) - longint'($signed(b.x));
      dy = longint'($signed(a.y)) - longint'($signed(b.y));
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return (2 * dx < longint'(a.w) + longint'(b.w)) &&
             (2 * dy < longint'(a.h) + longint'(b.h));
   endfunction

   function automatic void place_die(die_word_type d);
      verdict_type v;
      int          i;
      if (placed_count < DIES) begin
         for (i = 0; i < placed_count; i++)
            if (rects_clash(d.r, placed[i])) clash_seen = 1'b1;
         placed[placed_count] = d.r;
         placed_count++;
      end else begin
         // past capacity: drop without comparing
         spill_seen = 1'b1;
      end
      if (d.last) begin
         v.placement_valid   = !clash_seen;
         v.rect_count        = placed_count[COUNT_W-1:0];
         v.capacity_overflow = spill_seen;
         verdict_q = {verdict_q, v};
         placed_count = 0;
         clash_seen   = 1'b0;
         spill_seen   = 1'b0;
      end
   endfunction

   task automatic add_die(int x, int y, int w, int h, bit last);
      die_word_type d;
      d.r.x  = x[COORD_W-1:0];
      d.r.y  = y[COORD_W-1:0];
      d.r.w  = w[SIZE_W-1:0];
      d.r.h  = h[SIZE_W-1:0];
      d.last = last;
      die_q = {die_q, d};
   endtask

   // Styles: 0 full-range random, 1 tight cluster, 2 touching grid with an optional nudge
   task automatic add_random_set(int n, int style);
      int bx;
      int by;
      int sx;
      int sy;
      int k;
      int i;
      int x;
      bit nudge;
      bx    = int'($urandom_range(14000000)) - 7000000;
      by    = int'($urandom_range(14000000)) - 7000000;
      sx    = $urandom_range(20000, 1);
      sy    = $urandom_range(20000, 1);
      nudge = ($urandom_range(3) == 0);
      k     = $urandom_range(n - 1);
      for (i = 0; i < n; i++) begin
         case (style)
            0: add_die($urandom, $urandom, $urandom, $urandom, i == n - 1);
            1: add_die(bx + int'($urandom_range(4000)) - 2000,
                       by + int'($urandom_range(4000)) - 2000,
                       $urandom_range(800), $urandom_range(800), i == n - 1);
            default: begin
               x = bx + (i % 8) * sx;
               if (nudge && i == k) x += ($urandom_range(1) != 0) ? 1 : -1;
               add_die(x, by + (i / 8) * sy, sx, sy, i == n - 1);
            end
         endcase
      end
   endtask

   function automatic int pick_set_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 3) return $urandom_range(72, 60);
      if (roll < 12) return $urandom_range(24, 9);
      return $urandom_range(8, 1);
   endfunction

   task automatic add_phase_sets(int items);
      int n;
      int added;
      added = 0;
      while (added < items) begin
         n = pick_set_size();
         add_random_set(n, $urandom_range(2));
         added += n;
      end
   endtask

   task automatic wait_drained();
      while (die_q.size() != 0 || req_tvalid || verdict_q.size() != 0) @(negedge clock);
   endtask

   // Sender: advance on acceptance, predict the accepted word
   always @(posedge clock) begin : sender
      die_word_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) place_die(on_bus);
         if (die_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = die_q.pop_front();
            on_bus = nxt;
            req_tvalid <= 1'b1;
            req_tdata  <= {{(REQ_W - $bits(rect_type)){1'b0}}, nxt.r};
            req_tlast  <= nxt.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: check each result word, then choose the next ready
   always @(posedge clock) begin : receiver
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("unexpected result word", int'(rsp_tdata), -1);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_tdata[0] !== want.placement_valid)
               report_mismatch("placement_valid", int'(rsp_tdata[0]),
                               int'(want.placement_valid));
            if (rsp_tdata[7:1] !== want.rect_count)
               report_mismatch("rect_count", int'(rsp_tdata[7:1]), int'(want.rect_count));
            if (rsp_tdata[8] !== want.capacity_overflow)
               report_mismatch("capacity_overflow", int'(rsp_tdata[8]),
                               int'(want.capacity_overflow));
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen  <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** die_placement_overlap_check: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single rectangle at the coordinate extremes
      add_die(-8388608, 8388607, 8388607, 0, 1'b1);
      // opposite corners, full sizes: far apart
      add_die(-8388608, -8388608, 8388607, 8388607, 1'b0);
      add_die(8388607, 8388607, 8388607, 8388607, 1'b1);
      // edges touching on x: no overlap
      add_die(0, 0, 10, 10, 1'b0);
      add_die(10, 0, 10, 10, 1'b1);
      // overlap by one unit
      add_die(0, 0, 10, 10, 1'b0);
      add_die(9, 0, 10, 10, 1'b1);
      // zero sizes at the same center do not overlap
      add_die(5, 5, 0, 0, 1'b0);
      add_die(5, 5, 0, 0, 1'b1);
      // one zero width against a nonzero one does
      add_die(5, 5, 0, 4, 1'b0);
      add_die(5, 5, 1, 4, 1'b1);
      // x overlaps, y only touches
      add_die(0, 0, 100, 100, 1'b0);
      add_die(0, 100, 100, 100, 1'b1);
      // same center, largest against smallest
      add_die(100, -100, 8388607, 8388607, 1'b0);
      add_die(100, -100, 1, 1, 1'b1);
      // touching at the negative end, then a third that overlaps the first
      add_die(-8388608, 0, 2, 2, 1'b0);
      add_die(-8388606, 0, 2, 2, 1'b0);
      add_die(-8388607, 1, 1, 1, 1'b1);
      wait_drained();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         add_phase_sets(PHASE_ITEMS);
         if (phase == 0) begin
            // hold the output while words keep coming so the input backs up
            hold_req++;
            add_random_set(DIES, 2);
            add_random_set(DIES + 1, 1);
            add_random_set(DIES + 2, 0);
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("** die_placement_overlap_check: PASSED **");
      end else begin
         $display("** die_placement_overlap_check: FAILED **");
      end
      $finish;
   end

endmodule
